// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while out of reset.
`define DSCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define DSCD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/dscd_pkg.sv
// Types, codes and helper functions for the datagram sync checker and deframer.
// Depends on nothing; used by the parser, the result queue and the top level.
package dscd_pkg;

  localparam int RES_QUEUE_DEPTH = 4;

  // Sync and submessage tags.
  localparam logic [7:0] TAG_SYNC = 8'hEF;
  localparam logic [7:0] TAG_E3   = 8'hE3;
  localparam logic [7:0] TAG_E4   = 8'hE4;
  localparam logic [7:0] TAG_E5   = 8'hE5;

  // Letters that stand in for the hash bytes while hashing.
  localparam logic [7:0] SUBST_1 = 8'h42;
  localparam logic [7:0] SUBST_2 = 8'h54;
  localparam logic [7:0] SUBST_3 = 8'h45;

  // Parse phases.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_SYNC    = 3'd1;
  localparam logic [2:0] PH_FIRST   = 3'd2;
  localparam logic [2:0] PH_SUBHDR  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;
  localparam logic [2:0] PH_DRAIN   = 3'd6;

  // Result kinds.
  localparam logic [1:0] KIND_DESC    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // Submessage formats.
  localparam logic [1:0] FMT_E3 = 2'd0;
  localparam logic [1:0] FMT_E4 = 2'd1;
  localparam logic [1:0] FMT_E5 = 2'd2;

  // End status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_START   = 3'd1;
  localparam logic [2:0] ST_BAD_TAG     = 3'd2;
  localparam logic [2:0] ST_SHORT_HDR   = 3'd3;
  localparam logic [2:0] ST_HASH_FAIL   = 3'd4;
  localparam logic [2:0] ST_BAD_SUBTAG  = 3'd5;
  localparam logic [2:0] ST_BAD_SUBLEN  = 3'd6;
  localparam logic [2:0] ST_TRUNCATED   = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } dscd_in_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [1:0]  sub_format;
    logic [31:0] type_code;
    logic [23:0] payload_length;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic        last;
  } dscd_res_t;

  // Header size of a submessage; zero marks an unknown tag.
  function automatic logic [3:0] hdr_size(input logic [7:0] tag);
    logic [3:0] sz;
    case (tag)
      TAG_E3:  sz = 4'd6;
      TAG_E4:  sz = 4'd8;
      TAG_E5:  sz = 4'd4;
      default: sz = 4'd0;
    endcase
    return sz;
  endfunction

  function automatic logic [1:0] fmt_of(input logic [7:0] tag);
    logic [1:0] f;
    case (tag)
      TAG_E4:  f = FMT_E4;
      TAG_E5:  f = FMT_E5;
      default: f = FMT_E3;
    endcase
    return f;
  endfunction

  // x * 251 modulo 2^32, as 256x - 4x - x.
  function automatic logic [31:0] mul251(input logic [31:0] x);
    return (x << 8) - (x << 2) - x;
  endfunction

endpackage

// File: design/datagram_sync_check_and_deframer_unit.sv
// Datagram sync checker and deframer: one byte per request, results one per request.
// Results are formed combinationally from the taken byte and written into a register queue, whose head is offered.
// Throughput: one byte per cycle; a byte with two results offers them one after the other,
// and the input stalls while the result queue has fewer than two free entries.
// Reset: synchronous, active low; clears the parse state and empties the result queue.
`include "assert_macros.svh"

module datagram_sync_check_and_deframer_unit #(
  parameter int RES_DEPTH = dscd_pkg::RES_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dscd_pkg::dscd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dscd_pkg::dscd_res_t out_data
);
  import dscd_pkg::*;

  logic      in_acc;
  logic      out_pop;
  logic [1:0] res_n;
  dscd_res_t res0;
  dscd_res_t res1;

  assign in_acc  = in_valid && !in_stall;
  assign out_pop = out_valid && !out_stall;

  dscd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .in_data (in_data),
    .res_n   (res_n),
    .res0    (res0),
    .res1    (res1)
  );

  dscd_out_queue #(
    .DEPTH (RES_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (res_n),
    .push0     (res0),
    .push1     (res1),
    .pop       (out_pop),
    .not_empty (out_valid),
    .no_room   (in_stall),
    .head      (out_data)
  );

  `DSCD_ASSERT(a_status_is_last, out_valid && out_data.item_kind == KIND_STATUS |-> out_data.last, "end status result without last")
  `DSCD_ASSERT(a_desc_clean, out_valid && out_data.item_kind == KIND_DESC |-> out_data.status == ST_OK && out_data.payload_byte == 8'd0, "descriptor carries stray fields")
  `DSCD_ASSERT(a_payload_clean, out_valid && out_data.item_kind == KIND_PAYLOAD |-> out_data.type_code == 32'd0 && out_data.payload_length == 24'd0, "payload result carries descriptor fields")
  `DSCD_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid, "result offered right after reset")

endmodule

// File: design/dscd_parser.sv
// Byte-wise sync header check and submessage split; up to two results per byte.
// Depends on dscd_pkg.
module dscd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  dscd_pkg::dscd_in_t  in_data,
  output logic [1:0]          res_n,
  output dscd_pkg::dscd_res_t res0,
  output dscd_pkg::dscd_res_t res1
);
  import dscd_pkg::*;

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  offset_r, offset_nxt;
  // Holds the running hash already multiplied by 251.
  logic [31:0] hprod_r, hprod_nxt;
  logic [23:0] rx_hash_r, rx_hash_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [23:0] sub_len_r, sub_len_nxt;
  logic [31:0] code_r, code_nxt;
  logic [23:0] remain_r, remain_nxt;
  logic [2:0]  err_r, err_nxt;

  logic [7:0]  b;
  logic        eop;
  logic [7:0]  subst;
  logic [31:0] hprod_step;
  logic [3:0]  off_inc;
  logic [2:0]  off3;
  logic [1:0]  idx;
  logic        is_e5;
  logic [23:0] g_len;
  logic [31:0] g_code;
  logic [3:0]  hdr_sz;
  logic        close_now;
  logic        cl_bad;
  logic [23:0] cl_rem;
  logic [23:0] rem_dec;
  logic        main_vld;
  dscd_res_t   main_res;
  dscd_res_t   stat_res;
  logic [2:0]  eop_st;

  assign b   = in_data.data_byte;
  assign eop = in_data.end_of_packet;

  always_comb begin
    case (offset_r[1:0])
      2'd1:    subst = SUBST_1;
      2'd2:    subst = SUBST_2;
      2'd3:    subst = SUBST_3;
      default: subst = 8'd0;
    endcase
  end

  assign hprod_step = mul251(hprod_r + {24'd0, (phase_r == PH_SYNC) ? subst : b});

  // Field gathering for a submessage header byte.
  assign off_inc = offset_r + 4'd1;
  assign off3    = offset_r[2:0];
  assign is_e5   = (tag_r == TAG_E5);
  assign idx     = is_e5 ? 2'(off3 - 3'd2) : 2'(off3 - 3'd4);

  always_comb begin
    g_len  = sub_len_r;
    g_code = code_r;
    if (is_e5) begin
      if (off3 == 3'd1) begin
        g_len = {16'd0, b};
      end else if (off3 == 3'd2 || off3 == 3'd3) begin
        g_code = code_r | ({24'd0, b} << {idx, 3'b000});
      end
    end else begin
      if (off3 >= 3'd1 && off3 <= 3'd3) begin
        g_len = {sub_len_r[15:0], b};
      end else if (off3 >= 3'd4) begin
        g_code = code_r | ({24'd0, b} << {idx, 3'b000});
      end
    end
  end

  assign hdr_sz    = hdr_size(tag_r);
  assign close_now = (off_inc == hdr_sz);
  assign cl_bad    = (g_len < {20'd0, hdr_sz});
  assign cl_rem    = g_len - {20'd0, hdr_sz};
  assign rem_dec   = remain_r - 24'd1;

  always_comb begin
    phase_nxt   = phase_r;
    offset_nxt  = offset_r;
    hprod_nxt   = hprod_r;
    rx_hash_nxt = rx_hash_r;
    tag_nxt     = tag_r;
    sub_len_nxt = sub_len_r;
    code_nxt    = code_r;
    remain_nxt  = remain_r;
    err_nxt     = err_r;
    main_vld    = 1'b0;
    main_res    = '0;
    eop_st      = ST_OK;
    stat_res    = '0;

    if (acc) begin
      case (phase_r)
        PH_IDLE: begin
          hprod_nxt = mul251({24'd0, b});
          if (b != TAG_SYNC) begin
            err_nxt   = ST_BAD_START;
            phase_nxt = PH_DRAIN;
          end else begin
            phase_nxt  = PH_SYNC;
            offset_nxt = 4'd1;
          end
        end
        PH_SYNC: begin
          rx_hash_nxt = {rx_hash_r[15:0], b};
          hprod_nxt   = hprod_step;
          offset_nxt  = off_inc;
          if (off_inc >= 4'd4) begin
            phase_nxt  = PH_FIRST;
            offset_nxt = 4'd0;
          end
        end
        PH_FIRST, PH_SUBHDR: begin
          if (phase_r == PH_FIRST) begin
            hprod_nxt = hprod_step;
          end
          if (offset_r == 4'd0) begin
            if (phase_r == PH_SUBHDR && b == TAG_SYNC) begin
              phase_nxt  = PH_SKIP;
              remain_nxt = 24'd3;
            end else if (hdr_size(b) == 4'd0) begin
              err_nxt   = (phase_r == PH_FIRST) ? ST_BAD_TAG : ST_BAD_SUBTAG;
              phase_nxt = PH_DRAIN;
            end else begin
              tag_nxt     = b;
              sub_len_nxt = 24'd0;
              code_nxt    = 32'd0;
              offset_nxt  = 4'd1;
            end
          end else begin
            sub_len_nxt = g_len;
            code_nxt    = g_code;
            offset_nxt  = off_inc;
            if (close_now) begin
              if (phase_r == PH_FIRST && hprod_step[31:8] != rx_hash_r) begin
                err_nxt   = ST_HASH_FAIL;
                phase_nxt = PH_DRAIN;
              end else begin
                offset_nxt = 4'd0;
                if (cl_bad) begin
                  err_nxt   = ST_BAD_SUBLEN;
                  phase_nxt = PH_DRAIN;
                end else begin
                  remain_nxt              = cl_rem;
                  main_vld                = 1'b1;
                  main_res.item_kind      = KIND_DESC;
                  main_res.sub_format     = fmt_of(tag_r);
                  main_res.type_code      = g_code;
                  main_res.payload_length = cl_rem;
                  phase_nxt = (cl_rem != 24'd0) ? PH_PAYLOAD : PH_SUBHDR;
                end
              end
            end
          end
        end
        PH_PAYLOAD: begin
          main_vld              = 1'b1;
          main_res.item_kind    = KIND_PAYLOAD;
          main_res.payload_byte = b;
          remain_nxt            = rem_dec;
          if (rem_dec == 24'd0) begin
            phase_nxt = PH_SUBHDR;
          end
        end
        PH_SKIP: begin
          remain_nxt = rem_dec;
          if (rem_dec == 24'd0) begin
            phase_nxt = PH_SUBHDR;
          end
        end
        default: begin
        end
      endcase

      if (eop) begin
        if (phase_nxt == PH_DRAIN) begin
          eop_st = err_nxt;
        end else if (phase_nxt == PH_SYNC || phase_nxt == PH_FIRST) begin
          eop_st = ST_SHORT_HDR;
        end else if (phase_nxt == PH_SUBHDR && offset_nxt == 4'd0) begin
          eop_st = ST_OK;
        end else begin
          eop_st = ST_TRUNCATED;
        end
        stat_res.item_kind = KIND_STATUS;
        stat_res.status    = eop_st;
        stat_res.last      = 1'b1;
        // The end of a datagram always returns the parser to its reset state.
        phase_nxt   = PH_IDLE;
        offset_nxt  = 4'd0;
        hprod_nxt   = 32'd0;
        rx_hash_nxt = 24'd0;
        tag_nxt     = 8'd0;
        sub_len_nxt = 24'd0;
        code_nxt    = 32'd0;
        remain_nxt  = 24'd0;
        err_nxt     = ST_OK;
      end
    end
  end

  always_comb begin
    res0 = '0;
    res1 = '0;
    res_n = 2'd0;
    if (acc) begin
      if (main_vld) begin
        res0      = main_res;
        res0.last = !eop;
        res1      = stat_res;
        res_n     = eop ? 2'd2 : 2'd1;
      end else if (eop) begin
        res0  = stat_res;
        res_n = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      offset_r  <= 4'd0;
      hprod_r   <= 32'd0;
      rx_hash_r <= 24'd0;
      tag_r     <= 8'd0;
      sub_len_r <= 24'd0;
      code_r    <= 32'd0;
      remain_r  <= 24'd0;
      err_r     <= ST_OK;
    end else begin
      phase_r   <= phase_nxt;
      offset_r  <= offset_nxt;
      hprod_r   <= hprod_nxt;
      rx_hash_r <= rx_hash_nxt;
      tag_r     <= tag_nxt;
      sub_len_r <= sub_len_nxt;
      code_r    <= code_nxt;
      remain_r  <= remain_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

// File: design/dscd_out_queue.sv
// Small register queue for results; takes up to two per cycle, gives one.
// Depends on dscd_pkg.
module dscd_out_queue #(
  parameter int DEPTH = dscd_pkg::RES_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_n,
  input  dscd_pkg::dscd_res_t push0,
  input  dscd_pkg::dscd_res_t push1,
  input  logic                pop,
  output logic                not_empty,
  output logic                no_room,
  output dscd_pkg::dscd_res_t head
);
  import dscd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dscd_res_t         mem_r [DEPTH];
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     wr_ptr1;
  logic [CW-1:0]     count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_ptr1 = ptr_inc(wr_ptr_r);

  assign not_empty = (count_r != '0);
  // Room for two results is kept free so a byte never has to wait mid-request.
  assign no_room   = (count_r > CW'(DEPTH - 2));
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    case (push_n)
      2'd1:    wr_ptr_nxt = wr_ptr1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    count_nxt = count_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (push_n != 2'd0 && wr_ptr_r == PW'(i)) begin
        mem_r[i] <= push0;
      end else if (push_n == 2'd2 && wr_ptr1 == PW'(i)) begin
        mem_r[i] <= push1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: tb/tb_datagram_sync_check_and_deframer_unit.sv
// Testbench for the datagram sync checker and deframer: random and directed datagrams,
// predicted results held in a scoreboard class and checked field by field.
// Depends on dscd_pkg and datagram_sync_check_and_deframer_unit.
`timescale 1ns / 100ps

module tb_datagram_sync_check_and_deframer_unit;
  import dscd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int STIM_TARGET = 550;

  // Tracks the parse state of the block and holds the results it should give.
  class deframe_scoreboard;
    logic [2:0]  phase;
    logic [3:0]  offset;
    logic [31:0] hash_acc;
    logic [23:0] rx_hash;
    logic [7:0]  cur_tag;
    logic [23:0] sub_len;
    logic [31:0] code_bytes;
    logic [23:0] remaining;
    logic [2:0]  err_code;
    dscd_res_t   deframed_q[$];
    int          errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    static function logic [3:0] sub_header_size(logic [7:0] tag);
      case (tag)
        TAG_E3:  return 4'd6;
        TAG_E4:  return 4'd8;
        TAG_E5:  return 4'd4;
        default: return 4'd0;
      endcase
    endfunction

    function void clear_state();
      phase = PH_IDLE;
      offset = '0;
      hash_acc = '0;
      rx_hash = '0;
      cur_tag = '0;
      sub_len = '0;
      code_bytes = '0;
      remaining = '0;
      err_code = ST_OK;
    endfunction

    function void fail_with(logic [2:0] code);
      err_code = code;
      phase = PH_DRAIN;
    endfunction

    function void emit(logic [1:0] kind, logic [1:0] fmt, logic [31:0] code,
                       logic [23:0] len, logic [7:0] pb, logic [2:0] st);
      dscd_res_t r;
      r.item_kind = kind;
      r.sub_format = fmt;
      r.type_code = code;
      r.payload_length = len;
      r.payload_byte = pb;
      r.status = st;
      r.last = 1'b0;
      deframed_q.push_back(r);
    endfunction

    function void open_sub(logic [7:0] tag);
      cur_tag = tag;
      sub_len = '0;
      code_bytes = '0;
      offset = 4'd1;
    endfunction

    // Short submessages carry an 8-bit length; the others a 24-bit big-endian one.
    function void take_header_byte(logic [7:0] b);
      logic [2:0] off;
      off = offset[2:0];
      if (cur_tag == TAG_E5) begin
        if (off == 3'd1) sub_len = {16'd0, b};
        else if (off >= 3'd2 && off <= 3'd3) code_bytes |= {24'd0, b} << (8 * (off - 3'd2));
      end else begin
        if (off >= 3'd1 && off <= 3'd3) sub_len = {sub_len[15:0], b};
        else if (off >= 3'd4) code_bytes |= {24'd0, b} << (8 * (off - 3'd4));
      end
      offset = offset + 4'd1;
    endfunction

    function void close_sub();
      logic [3:0] hl;
      hl = sub_header_size(cur_tag);
      offset = '0;
      if (sub_len < {20'd0, hl}) begin
        fail_with(ST_BAD_SUBLEN);
        return;
      end
      remaining = sub_len - {20'd0, hl};
      emit(KIND_DESC, (cur_tag == TAG_E4) ? FMT_E4 : (cur_tag == TAG_E5) ? FMT_E5 : FMT_E3,
           code_bytes, remaining, '0, ST_OK);
      phase = (remaining != '0) ? PH_PAYLOAD : PH_SUBHDR;
    endfunction

    function void note_request(dscd_in_t req);
      logic [7:0]  b;
      logic [31:0] h;
      logic [2:0]  st;
      dscd_res_t   r;
      int          n_prior;
      b = req.data_byte;
      n_prior = deframed_q.size();
      case (phase)
        PH_IDLE: begin
          hash_acc = {24'd0, b};
          if (b != TAG_SYNC) fail_with(ST_BAD_START);
          else begin
            phase = PH_SYNC;
            offset = 4'd1;
          end
        end
        PH_SYNC: begin
          rx_hash = {rx_hash[15:0], b};
          // The hash bytes themselves are hashed as fixed letters.
          case (offset[1:0])
            2'd1:    h = {24'd0, SUBST_1};
            2'd2:    h = {24'd0, SUBST_2};
            2'd3:    h = {24'd0, SUBST_3};
            default: h = '0;
          endcase
          hash_acc = hash_acc * 32'd251 + h;
          offset = offset + 4'd1;
          if (offset >= 4'd4) begin
            phase = PH_FIRST;
            offset = '0;
          end
        end
        PH_FIRST: begin
          hash_acc = hash_acc * 32'd251 + {24'd0, b};
          if (offset == 4'd0) begin
            if (sub_header_size(b) == 4'd0) fail_with(ST_BAD_TAG);
            else open_sub(b);
          end else begin
            take_header_byte(b);
            if (offset == sub_header_size(cur_tag)) begin
              h = hash_acc * 32'd251;
              if (h[31:8] != rx_hash) fail_with(ST_HASH_FAIL);
              else close_sub();
            end
          end
        end
        PH_SUBHDR: begin
          if (offset == 4'd0) begin
            if (b == TAG_SYNC) begin
              phase = PH_SKIP;
              remaining = 24'd3;
            end else if (sub_header_size(b) == 4'd0) fail_with(ST_BAD_SUBTAG);
            else open_sub(b);
          end else begin
            take_header_byte(b);
            if (offset == sub_header_size(cur_tag)) close_sub();
          end
        end
        PH_PAYLOAD: begin
          emit(KIND_PAYLOAD, '0, '0, '0, b, ST_OK);
          remaining = remaining - 24'd1;
          if (remaining == '0) phase = PH_SUBHDR;
        end
        PH_SKIP: begin
          remaining = remaining - 24'd1;
          if (remaining == '0) phase = PH_SUBHDR;
        end
        default: ;
      endcase
      if (req.end_of_packet) begin
        if (phase == PH_DRAIN) st = err_code;
        else if (phase == PH_SYNC || phase == PH_FIRST) st = ST_SHORT_HDR;
        else if (phase == PH_SUBHDR && offset == 4'd0) st = ST_OK;
        else st = ST_TRUNCATED;
        emit(KIND_STATUS, '0, '0, '0, '0, st);
        clear_state();
      end
      if (deframed_q.size() > n_prior) begin
        r = deframed_q.pop_back();
        r.last = 1'b1;
        deframed_q.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(dscd_res_t got);
      dscd_res_t want;
      if (deframed_q.size() == 0) begin
        $error("result of kind %0d arrived with none awaited", got.item_kind);
        errors++;
        return;
      end
      want = deframed_q.pop_front();
      compare_field("item_kind", 32'(want.item_kind), 32'(got.item_kind));
      compare_field("sub_format", 32'(want.sub_format), 32'(got.sub_format));
      compare_field("type_code", want.type_code, got.type_code);
      compare_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
      compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  dscd_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  dscd_res_t out_data;

  deframe_scoreboard sb;
  dscd_in_t          stim_q[$];
  logic [7:0]        pkt[$];
  int                requests_taken;
  int unsigned       cycle_count;

  datagram_sync_check_and_deframer_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("datagram_sync_check_and_deframer_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Datagram construction
  // ---------------------------------------------------------------------------

  task automatic begin_datagram();
    pkt.delete();
    pkt.push_back(TAG_SYNC);
    repeat (3) pkt.push_back(8'h00);
  endtask

  task automatic append_sub(logic [7:0] tag, logic [23:0] total, int n_pay);
    int start;
    int hl;
    start = pkt.size();
    hl = int'(deframe_scoreboard::sub_header_size(tag));
    pkt.push_back(tag);
    if (tag == TAG_E5) pkt.push_back(total[7:0]);
    else begin
      pkt.push_back(total[23:16]);
      pkt.push_back(total[15:8]);
      pkt.push_back(total[7:0]);
    end
    while (pkt.size() < start + hl) pkt.push_back(8'($urandom));
    repeat (n_pay) pkt.push_back(8'($urandom));
  endtask

  task automatic append_skip();
    pkt.push_back(TAG_SYNC);
    repeat (3) pkt.push_back(8'($urandom));
  endtask

  // Fills bytes 1..3 with the hash over the sync header and the first submessage header.
  task automatic seal_header();
    logic [31:0] h;
    int          hl;
    h = {24'd0, TAG_SYNC};
    h = h * 32'd251 + {24'd0, SUBST_1};
    h = h * 32'd251 + {24'd0, SUBST_2};
    h = h * 32'd251 + {24'd0, SUBST_3};
    hl = int'(deframe_scoreboard::sub_header_size(pkt[4]));
    for (int i = 0; i < hl; i++) h = h * 32'd251 + {24'd0, pkt[4 + i]};
    h = h * 32'd251;
    pkt[1] = h[31:24];
    pkt[2] = h[23:16];
    pkt[3] = h[15:8];
  endtask

  task automatic commit_packet(int keep);
    dscd_in_t req;
    for (int i = 0; i < keep; i++) begin
      req.data_byte = pkt[i];
      req.end_of_packet = (i == keep - 1);
      stim_q.push_back(req);
    end
  endtask

  function automatic logic [7:0] pick_tag();
    case ($urandom_range(2))
      0:       return TAG_E3;
      1:       return TAG_E4;
      default: return TAG_E5;
    endcase
  endfunction

  function automatic int pick_payload_len();
    if ($urandom_range(9) == 0) return $urandom_range(40, 7);
    return $urandom_range(6, 0);
  endfunction

  task automatic make_random_datagram();
    int          mode;
    int          keep;
    int          n;
    int          hl;
    logic [7:0]  t;
    logic [7:0]  bad;
    logic [23:0] total;
    mode = $urandom_range(99);
    if (mode >= 91) begin
      pkt.delete();
      repeat ($urandom_range(8, 1)) pkt.push_back(8'($urandom));
      if ($urandom_range(1) == 1) pkt[0] = TAG_SYNC;
      commit_packet(pkt.size());
      return;
    end
    begin_datagram();
    t = pick_tag();
    hl = int'(deframe_scoreboard::sub_header_size(t));
    n = pick_payload_len();
    if (mode >= 86 && mode <= 88) append_sub(t, 24'($urandom_range(hl - 1, 0)), 0);
    else if (mode >= 60 && mode <= 67 && $urandom_range(3) == 0) begin
      // A huge length that the datagram ends long before reaching.
      total = 24'($urandom) | 24'h800000;
      append_sub(t, total, n);
    end else append_sub(t, 24'(hl + n), n);
    repeat ($urandom_range(3)) begin
      if ($urandom_range(4) == 0) append_skip();
      else begin
        t = pick_tag();
        n = pick_payload_len();
        append_sub(t, 24'(int'(deframe_scoreboard::sub_header_size(t)) + n), n);
      end
    end
    seal_header();
    keep = pkt.size();
    if (mode >= 60 && mode <= 67) keep = $urandom_range(pkt.size() - 1, 1);
    else if (mode >= 68 && mode <= 71) begin
      do bad = 8'($urandom); while (bad == TAG_SYNC);
      pkt[0] = bad;
      keep = $urandom_range(3, 1);
    end else if (mode >= 72 && mode <= 75) begin
      do bad = 8'($urandom); while (bad == TAG_E3 || bad == TAG_E4 || bad == TAG_E5);
      pkt[4] = bad;
      keep = $urandom_range(pkt.size(), 5);
    end else if (mode >= 76 && mode <= 80) begin
      n = $urandom_range(3, 1);
      pkt[n] = pkt[n] ^ (8'h01 << $urandom_range(7));
    end else if (mode >= 81 && mode <= 85) begin
      do bad = 8'($urandom);
      while (bad == TAG_E3 || bad == TAG_E4 || bad == TAG_E5 || bad == TAG_SYNC);
      pkt.push_back(bad);
      repeat ($urandom_range(2)) pkt.push_back(8'($urandom));
      keep = pkt.size();
    end else if (mode >= 89 && mode <= 90) begin
      t = pick_tag();
      hl = int'(deframe_scoreboard::sub_header_size(t));
      append_sub(t, 24'($urandom_range(hl - 1, 0)), 0);
      repeat ($urandom_range(2)) pkt.push_back(8'($urandom));
      keep = pkt.size();
    end
    commit_packet(keep);
  endtask

  task automatic build_stimulus();
    // Bad start byte on a one-byte datagram.
    pkt.delete();
    pkt.push_back(8'h00);
    commit_packet(1);
    // Datagram that ends before the tag is reached.
    begin_datagram();
    commit_packet(3);
    // Unknown first tag; the byte after it is ignored until the end.
    begin_datagram();
    pkt.push_back(8'h12);
    pkt.push_back(8'hFF);
    commit_packet(6);
    // Short submessage with no payload, ending cleanly: descriptor and status together.
    begin_datagram();
    append_sub(TAG_E5, 24'd4, 0);
    seal_header();
    commit_packet(pkt.size());
    // Largest length, cut after one payload byte.
    begin_datagram();
    append_sub(TAG_E3, 24'hFFFFFF, 1);
    seal_header();
    commit_packet(pkt.size());
    while (stim_q.size() < STIM_TARGET) make_random_datagram();
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  task automatic run_sender();
    int idx;
    idx = 0;
    forever begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        sb.note_request(in_data);
        requests_taken++;
      end
      if (!(in_valid && in_stall)) begin
        if (idx < stim_q.size() && ((idx >= 150 && idx < 300) || $urandom_range(99) >= 18)) begin
          in_valid <= 1'b1;
          in_data <= stim_q[idx];
          idx++;
        end else in_valid <= 1'b0;
      end
    end
  endtask

  task automatic run_receiver();
    int got;
    int hold_left;
    bit held;
    got = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
        got++;
      end
      // One long hold-off so the result queue fills and the input backs up.
      if (!held && got >= 30) begin
        held = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (got >= 60 && got < 200) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < 18);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    requests_taken = 0;
    cycle_count = 0;
    sb = new();
    build_stimulus();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    fork
      run_sender();
      run_receiver();
    join_none
    while (requests_taken < stim_q.size()) @(posedge clk);
    while (sb.deframed_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.deframed_q.size() == 0) begin
      $display("datagram_sync_check_and_deframer_unit verification clean");
    end else begin
      $display("datagram_sync_check_and_deframer_unit verification failed");
    end
    $finish;
  end

endmodule
